// ===== rtl/pdbp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pdbp_pkg
// Shared types and codes of the packet deframer with its buffer pool.
// ----------------------------------------------------------------------------
package pdbp_pkg;

  // Item opcodes
  localparam logic OP_RX   = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [1:0] CFG_MAX_LENGTH  = 2'd2;

  // Configuration reset values
  localparam logic [7:0] SYNC_FIRST_RST  = 8'd34;
  localparam logic [7:0] SYNC_SECOND_RST = 8'd105;
  localparam logic [7:0] MAX_LENGTH_RST  = 8'd251;

  typedef enum logic [1:0] {
    PS_SYNC1,
    PS_SYNC2,
    PS_LEN,
    PS_DATA
  } parse_state_t;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [7:0] max_length;
  } cfg_t;

  typedef struct packed {
    logic        data_valid;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [7:0]  message_length;
    logic        all_empty;
    logic        frame_done;
    logic [31:0] packet_count;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/packet_deframer_buffer_pool.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// packet_deframer_buffer_pool
// Sync/length framed packet receiver with a pool of message buffers.
// ----------------------------------------------------------------------------
// Each input beat is either a received link byte (opcode 0) or a request for
// the next message byte (opcode 1); every beat yields exactly one result beat.
// Frames are two sync bytes, a length byte and that many payload bytes. A good
// length claims the lowest free buffer (the packet is skipped if none is free);
// a completed payload marks the buffer ready and bumps packet_count. Reads
// return the lowest ready message byte by byte and release the buffer on its
// last byte; a message that has been partly read is finished first. The block
// takes one beat per cycle unless stalled: each beat does at most one access
// to the payload RAM (a write for a payload byte, a read for a message byte),
// and the rest of the state sits in flops updated in the same cycle. Results
// go through the registered RAM read with the read-data stage, then the
// output register. Input stall rises only while both the read-data stage and
// the output register hold beats and the output is stalled. The payload RAM
// needs no clearing pass after reset. The user must write the configuration
// registers via the cfg port only while no beat is in flight (not enforced).
// ----------------------------------------------------------------------------
module packet_deframer_buffer_pool #(
  parameter int NUM_BUFFERS  = 2,
  parameter int BUFFER_BYTES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input channel
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic        opcode,
  input  wire logic [7:0]  rx_byte,
  // result channel
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic             data_valid,
  output logic [7:0]       data_byte,
  output logic             last_byte,
  output logic [7:0]       message_length,
  output logic             all_empty,
  output logic             frame_done,
  output logic [31:0]      packet_count,
  // configuration
  input  wire logic        cfg_write_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  localparam int Depth = NUM_BUFFERS * BUFFER_BYTES;
  localparam int AddrW = $clog2(Depth);

  pdbp_pkg::cfg_t    cfg;
  pdbp_pkg::result_t stage;
  pdbp_pkg::result_t result;

  logic             accept;
  logic             ram_wr_en;
  logic [AddrW-1:0] ram_wr_addr;
  logic [7:0]       ram_wr_data;
  logic             ram_rd_en;
  logic [AddrW-1:0] ram_rd_addr;
  logic [7:0]       ram_rd_data;

  assign accept = item_valid && !item_stall;

  // Configuration registers; writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_first  <= pdbp_pkg::SYNC_FIRST_RST;
      cfg.sync_second <= pdbp_pkg::SYNC_SECOND_RST;
      cfg.max_length  <= pdbp_pkg::MAX_LENGTH_RST;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        pdbp_pkg::CFG_SYNC_FIRST:  cfg.sync_first  <= cfg_data;
        pdbp_pkg::CFG_SYNC_SECOND: cfg.sync_second <= cfg_data;
        pdbp_pkg::CFG_MAX_LENGTH:  cfg.max_length  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Parser, allocation and read pointer
  pdbp_ctrl #(
    .NUM_BUFFERS  (NUM_BUFFERS),
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .accept      (accept),
    .opcode      (opcode),
    .rx_byte     (rx_byte),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .stage       (stage)
  );

  // Payload store, one region of BUFFER_BYTES per buffer
  pdbp_ram #(
    .WIDTH (8),
    .DEPTH (Depth)
  ) u_payload (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Read-data stage and output register
  pdbp_out u_out (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .stage        (stage),
    .ram_rd_data  (ram_rd_data),
    .result_stall (result_stall),
    .hold         (item_stall),
    .result_valid (result_valid),
    .result       (result)
  );

  assign data_valid     = result.data_valid;
  assign data_byte      = result.data_byte;
  assign last_byte      = result.last_byte;
  assign message_length = result.message_length;
  assign all_empty      = result.all_empty;
  assign frame_done     = result.frame_done;
  assign packet_count   = result.packet_count;

`ifndef SYNTHESIS
  // Input may only back up when the output register is occupied
  a_stall_needs_full_out: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid)
    else $error("input stalled with empty output register");

  // A beat is either a received byte or a read, never both
  a_done_xor_read: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(frame_done && data_valid))
    else $error("frame_done and data_valid on one beat");

  // Last byte only on a returned byte of a nonempty message
  a_last_has_data: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last_byte) |-> (data_valid && message_length != 8'd0))
    else $error("last_byte without message data");

  // A returned message byte always carries its nonzero message length
  a_read_nonempty_len: assert property (@(posedge clk) disable iff (rst)
    (result_valid && data_valid) |-> (message_length != 8'd0))
    else $error("message byte returned with zero length");
`endif

endmodule
`default_nettype wire

// ===== rtl/pdbp_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pdbp_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pdbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AddrW-1:0] wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AddrW-1:0] rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pdbp_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pdbp_ctrl
// Frame parser, buffer allocation, ready flags and read pointer; issues at most
// one payload RAM access per item and builds the item's result (less the byte).
// ----------------------------------------------------------------------------
module pdbp_ctrl #(
  parameter int NUM_BUFFERS  = 2,
  parameter int BUFFER_BYTES = 256,
  localparam int BufW  = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1,
  localparam int OffW  = $clog2(BUFFER_BYTES),
  localparam int AddrW = $clog2(NUM_BUFFERS * BUFFER_BYTES)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire pdbp_pkg::cfg_t   cfg,
  input  wire logic             accept,
  input  wire logic             opcode,
  input  wire logic [7:0]       rx_byte,
  output logic                  ram_wr_en,
  output logic      [AddrW-1:0] ram_wr_addr,
  output logic      [7:0]       ram_wr_data,
  output logic                  ram_rd_en,
  output logic      [AddrW-1:0] ram_rd_addr,
  output pdbp_pkg::result_t     stage
);

  localparam logic [8:0] BufBytes9 = 9'(BUFFER_BYTES);

  pdbp_pkg::parse_state_t state, state_next;

  logic [NUM_BUFFERS-1:0] ready, ready_next;
  logic [7:0]             lengths [NUM_BUFFERS];
  logic                   len_we;
  logic [BufW-1:0]        fill_buffer, fill_buffer_next;
  logic [OffW-1:0]        fill_offset, fill_offset_next;
  logic [7:0]             fill_length, fill_length_next;
  logic [BufW-1:0]        read_buffer, read_buffer_next;
  logic [OffW-1:0]        read_offset, read_offset_next;
  logic [31:0]            count, count_next;

  logic            free_found, ready_found, cont, found;
  logic [BufW-1:0] free_idx, ready_idx, sel_buf;
  logic [OffW-1:0] sel_off;
  logic [7:0]      sel_len;

  function automatic logic [AddrW-1:0] buf_addr(logic [BufW-1:0] b, logic [OffW-1:0] o);
    buf_addr = AddrW'(b) * AddrW'(BUFFER_BYTES) + AddrW'(o);
  endfunction

  // Lowest free and lowest ready buffer
  always_comb begin
    free_found  = 1'b0;
    free_idx    = '0;
    ready_found = 1'b0;
    ready_idx   = '0;
    for (int i = NUM_BUFFERS - 1; i >= 0; i--) begin
      if (!ready[i]) begin
        free_found = 1'b1;
        free_idx   = BufW'(i);
      end
      if (ready[i]) begin
        ready_found = 1'b1;
        ready_idx   = BufW'(i);
      end
    end
  end

  always_comb begin
    cont    = (read_offset != '0) && ready[read_buffer];
    sel_buf = cont ? read_buffer : ready_idx;
    sel_off = cont ? read_offset : '0;
    found   = cont || ready_found;
    sel_len = lengths[sel_buf];
  end

  always_comb begin
    state_next       = state;
    ready_next       = ready;
    len_we           = 1'b0;
    fill_buffer_next = fill_buffer;
    fill_offset_next = fill_offset;
    fill_length_next = fill_length;
    read_buffer_next = read_buffer;
    read_offset_next = read_offset;
    count_next       = count;
    ram_wr_en        = 1'b0;
    ram_wr_addr      = buf_addr(fill_buffer, fill_offset);
    ram_wr_data      = rx_byte;
    ram_rd_en        = 1'b0;
    ram_rd_addr      = buf_addr(sel_buf, sel_off);
    stage            = '0;

    if (accept) begin
      if (opcode == pdbp_pkg::OP_RX) begin
        unique case (state)
          pdbp_pkg::PS_SYNC1: begin
            if (rx_byte == cfg.sync_first) begin
              state_next = pdbp_pkg::PS_SYNC2;
            end
          end
          pdbp_pkg::PS_SYNC2: begin
            if (rx_byte == cfg.sync_second) begin
              state_next = pdbp_pkg::PS_LEN;
            end
          end
          pdbp_pkg::PS_LEN: begin
            if (rx_byte == 8'd0 || rx_byte > cfg.max_length || 9'(rx_byte) > BufBytes9) begin
              state_next = pdbp_pkg::PS_SYNC2;
            end else if (!free_found) begin
              fill_buffer_next = '0;
              state_next       = pdbp_pkg::PS_SYNC1;
            end else begin
              fill_buffer_next = free_idx;
              fill_length_next = rx_byte;
              fill_offset_next = '0;
              len_we           = 1'b1;
              state_next       = pdbp_pkg::PS_DATA;
            end
          end
          pdbp_pkg::PS_DATA: begin
            ram_wr_en        = 1'b1;
            fill_offset_next = fill_offset + OffW'(1);
            if (9'(fill_offset) + 9'd1 == 9'(fill_length)) begin
              ready_next[fill_buffer] = 1'b1;
              state_next              = pdbp_pkg::PS_SYNC1;
              count_next              = count + 32'd1;
              stage.frame_done        = 1'b1;
            end
          end
          default: begin
            state_next = pdbp_pkg::PS_SYNC1;
          end
        endcase
      end else if (found) begin
        ram_rd_en            = 1'b1;
        read_buffer_next     = sel_buf;
        stage.data_valid     = 1'b1;
        stage.message_length = sel_len;
        if (9'(sel_off) + 9'd1 >= 9'(sel_len)) begin
          stage.last_byte     = 1'b1;
          ready_next[sel_buf] = 1'b0;
          read_offset_next    = '0;
        end else begin
          read_offset_next = sel_off + OffW'(1);
        end
      end else begin
        read_offset_next = '0;
      end
    end

    stage.all_empty    = ~|ready_next;
    stage.packet_count = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= pdbp_pkg::PS_SYNC1;
      ready       <= '0;
      fill_buffer <= '0;
      fill_offset <= '0;
      fill_length <= '0;
      read_buffer <= '0;
      read_offset <= '0;
      count       <= '0;
    end else begin
      state       <= state_next;
      ready       <= ready_next;
      fill_buffer <= fill_buffer_next;
      fill_offset <= fill_offset_next;
      fill_length <= fill_length_next;
      read_buffer <= read_buffer_next;
      read_offset <= read_offset_next;
      count       <= count_next;
    end
  end

  // Stored lengths are only read after being written
  always_ff @(posedge clk) begin
    if (len_we) begin
      lengths[free_idx] <= rx_byte;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pdbp_out.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pdbp_out
// Two-deep result pipe: a stage that waits for the RAM read data, then the
// output register. Stalls the input only when both are full.
// ----------------------------------------------------------------------------
module pdbp_out (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire pdbp_pkg::result_t stage,
  input  wire logic [7:0]        ram_rd_data,
  input  wire logic              result_stall,
  output logic                   hold,
  output logic                   result_valid,
  output pdbp_pkg::result_t      result
);

  logic              s1_valid;
  pdbp_pkg::result_t s1;
  pdbp_pkg::result_t s1_merged;
  logic              advance;

  assign advance = s1_valid && (!result_valid || !result_stall);
  assign hold    = s1_valid && !advance;

  // Merge the RAM read data into the waiting beat
  always_comb begin
    s1_merged           = s1;
    s1_merged.data_byte = s1.data_valid ? ram_rd_data : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= stage;
    end
    if (advance) begin
      result <= s1_merged;
    end
  end

endmodule
`default_nettype wire
